// ===== src/emergency_priority_green_selector_defines.svh =====
// assertion macros for the emergency priority green selector
// no dependencies; included by the files that carry assertions
`ifndef EMERGENCY_PRIORITY_GREEN_SELECTOR_DEFINES_SVH
`define EMERGENCY_PRIORITY_GREEN_SELECTOR_DEFINES_SVH

// same-cycle implication
`define EPGS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define EPGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/epgs_pkg.sv =====
// shared types and constants of the emergency priority green selector
// no dependencies
package epgs_pkg;

  localparam int NUM_ROADS_DEF = 4;

  localparam int COUNT_W  = 10;
  localparam int WAIT_W   = 16;
  localparam int DUR_W    = 10;
  localparam int TOTAL_W  = 12;
  localparam int ROAD_W   = 2;
  localparam int OP_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [WAIT_W-1:0]  WAIT_MAX  = 16'd65535;
  localparam logic [WAIT_W-1:0]  WAIT_STEP = 16'd10;
  localparam int                 TOTAL_MAX = 4095;

  localparam logic [DUR_W-1:0] MIN_GREEN_RST = 10'd10;
  localparam logic [DUR_W-1:0] MAX_GREEN_RST = 10'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_GREEN = 1'b0,
    REG_MAX_GREEN = 1'b1
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_EMERG  = 3'd2,
    OP_DECIDE = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SWEEP,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               flag;
    logic [WAIT_W-1:0]  waiting;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/epgs_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module epgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/emergency_priority_green_selector.sv =====
// add, remove and emergency words on a valid road pass through a read-modify-write
// state; tick and decide words run the sweep that reads one road entry per cycle, and
// decide adds a finishing state; the result register lets the next word start while
// a result waits, a stalled result holds the block in its last cycle
// synchronous reset: zero counts, waits and flags via per-road valid bits, no green,
// min_green 10, max_green 60; uses epgs_pkg, epgs_ram and the assertion macro header
`include "emergency_priority_green_selector_defines.svh"

module emergency_priority_green_selector #(
  parameter int NUM_ROADS = epgs_pkg::NUM_ROADS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [epgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [epgs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [epgs_pkg::OP_W-1:0]      operation,
  input  logic [epgs_pkg::ROAD_W-1:0]    road,
  input  logic                           is_ambulance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [epgs_pkg::ROAD_W-1:0]    green_road,
  output logic                           green_valid,
  output logic                           is_emergency,
  output logic [epgs_pkg::DUR_W-1:0]     green_duration,
  output logic [epgs_pkg::COUNT_W-1:0]   road_count,
  output logic [epgs_pkg::TOTAL_W-1:0]   total_vehicles
);

  import epgs_pkg::*;

  localparam int RW  = $clog2(NUM_ROADS);
  localparam int RXW = RW + ROAD_W;
  localparam int TW  = $clog2(NUM_ROADS * 1023 + 1);
  localparam int SW  = WAIT_W + 1;
  localparam logic [RW-1:0] LAST = RW'(NUM_ROADS - 1);

  state_t state, state_next;

  op_t              op_q;
  logic [RW-1:0]    road_q;
  logic             road_ok_q;
  logic             amb_q;
  logic [RW-1:0]    pidx;
  logic             rvalid_q;
  logic [NUM_ROADS-1:0] ent_valid;

  logic [DUR_W-1:0]   min_green;
  logic [DUR_W-1:0]   max_green;
  logic [RW-1:0]      active_road;
  logic               active_valid;
  logic               emergency_decision;
  logic [DUR_W-1:0]   granted_green;
  logic [TW-1:0]      total;
  logic [TW-1:0]      total_next;
  logic [COUNT_W-1:0] cnt_q;

  logic               emg_found;
  logic [RW-1:0]      emg_road;
  logic [SW-1:0]      best_score;
  logic [RW-1:0]      best_road;
  logic [COUNT_W-1:0] best_count;

  logic [RXW-1:0]     road_x;
  logic [RW-1:0]      road_addr_in;
  logic               road_ok_in;
  logic               accept;
  logic               sweep_op_in;
  logic               out_free;

  logic               ram_we;
  logic [RW-1:0]      ram_waddr;
  logic [RW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  entry_t             upd;
  logic               is_green;
  logic [SW-1:0]      score;
  logic [DUR_W:0]     dur_sum;
  logic [DUR_W-1:0]   dur;
  logic [RXW-1:0]     act_x;

  assign road_x       = RXW'(road);
  assign road_addr_in = road_x[RW-1:0];
  assign road_ok_in   = (32'(road) < NUM_ROADS);
  assign accept       = in_valid && !in_stall;
  assign sweep_op_in  = (op_t'(operation) == OP_DECIDE) || (op_t'(operation) == OP_TICK);
  assign out_free     = !out_valid || !out_stall;

  epgs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_ROADS)
  ) u_road_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(upd),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent = rvalid_q ? entry_t'(ram_rdata) : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sweep_op_in) begin
            state_next = ST_SWEEP;
          end else if (road_ok_in) begin
            state_next = ST_RMW;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RMW: state_next = ST_DONE;
      ST_SWEEP: begin
        if (pidx == LAST) begin
          state_next = (op_q == OP_DECIDE) ? ST_FIN : ST_DONE;
        end
      end
      ST_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_raddr = pidx + 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = sweep_op_in ? '0 : road_addr_in;
      end
      ST_RMW: begin
        ram_waddr = road_q;
        case (op_q) inside
          OP_ADD, OP_REMOVE, OP_EMERG: ram_we = 1'b1;
          default: ram_we = 1'b0;
        endcase
      end
      ST_SWEEP: ram_we = (op_q == OP_TICK);
      ST_FIN, ST_DONE: ram_we = 1'b0;
      default: ram_we = 1'b0;
    endcase
  end

  // entry update
  always_comb begin
    upd        = ent;
    total_next = total;
    is_green   = active_valid && (pidx == active_road);
    if (state == ST_RMW) begin
      case (op_q)
        OP_ADD: begin
          if (ent.count != COUNT_MAX) begin
            upd.count  = ent.count + 1'b1;
            total_next = total + 1'b1;
          end
          if (amb_q) begin
            upd.flag = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (ent.count != '0) begin
            upd.count  = ent.count - 1'b1;
            total_next = total - 1'b1;
          end
        end
        OP_EMERG: upd.flag = 1'b1;
        default: upd = ent;
      endcase
    end else if (state == ST_SWEEP && op_q == OP_TICK) begin
      if (is_green) begin
        if (ent.count != '0) begin
          upd.count  = ent.count - 1'b1;
          total_next = total - 1'b1;
          if (ent.waiting >= WAIT_STEP) begin
            upd.waiting = ent.waiting - WAIT_STEP;
          end
        end
      end else if (ent.count != '0) begin
        upd.waiting = (ent.waiting > WAIT_MAX - WAIT_STEP) ? WAIT_MAX
                                                           : ent.waiting + WAIT_STEP;
      end
    end
  end

  assign score   = SW'(ent.count) + SW'(ent.waiting);
  assign dur_sum = {1'b0, min_green} + {1'b0, best_count};
  assign dur     = (dur_sum > {1'b0, max_green}) ? max_green : dur_sum[DUR_W-1:0];
  assign act_x   = RXW'(active_road);

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      pidx               <= '0;
      ent_valid          <= '0;
      rvalid_q           <= 1'b0;
      min_green          <= MIN_GREEN_RST;
      max_green          <= MAX_GREEN_RST;
      active_road        <= '0;
      active_valid       <= 1'b0;
      emergency_decision <= 1'b0;
      granted_green      <= '0;
      total              <= '0;
      emg_found          <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state    <= state_next;
      rvalid_q <= (32'(ram_raddr) < NUM_ROADS) && ent_valid[ram_raddr];
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MIN_GREEN: min_green <= cfg_data;
          REG_MAX_GREEN: max_green <= cfg_data;
          default: min_green <= min_green;
        endcase
      end
      if (accept) begin
        pidx      <= '0;
        emg_found <= 1'b0;
      end
      if (state == ST_RMW) begin
        total <= total_next;
      end
      if (state == ST_SWEEP) begin
        pidx  <= pidx + 1'b1;
        total <= total_next;
        if (op_q == OP_DECIDE && !emg_found && ent.flag) begin
          emg_found <= 1'b1;
        end
      end
      if (state == ST_FIN) begin
        active_valid       <= 1'b1;
        emergency_decision <= emg_found;
        active_road        <= emg_found ? emg_road : best_road;
        granted_green      <= emg_found ? max_green : dur;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // word and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(operation);
      road_q    <= road_addr_in;
      road_ok_q <= road_ok_in;
      amb_q     <= is_ambulance;
      cnt_q     <= '0;
    end
    if (state == ST_RMW) begin
      cnt_q <= upd.count;
    end
    if (state == ST_SWEEP) begin
      if (road_ok_q && pidx == road_q) begin
        cnt_q <= upd.count;
      end
      if (!emg_found && ent.flag) begin
        emg_road <= pidx;
      end
      if (pidx == '0 || score > best_score) begin
        best_score <= score;
        best_road  <= pidx;
        best_count <= ent.count;
      end
    end
    if (state == ST_DONE && out_free) begin
      green_road     <= active_valid ? act_x[ROAD_W-1:0] : '0;
      green_valid    <= active_valid;
      is_emergency   <= emergency_decision;
      green_duration <= granted_green;
      road_count     <= cnt_q;
      total_vehicles <= (32'(total) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(total);
    end
  end

  `EPGS_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)
  `EPGS_ASSERT_NOW(a_sweep_in_range, clk, rst, state == ST_SWEEP,
                   32'(pidx) < NUM_ROADS)
  `EPGS_ASSERT_NOW(a_no_green_clean, clk, rst, out_valid && !green_valid,
                   green_road == '0 && !is_emergency && green_duration == '0)
  `EPGS_ASSERT_NOW(a_emerg_has_green, clk, rst, out_valid && is_emergency, green_valid)

endmodule

// ===== sim/emergency_priority_green_selector_tb.sv =====
// self-checking testbench for emergency_priority_green_selector: directed table, then
// random words with random idling on both sides, checked against a junction predictor
// depends on epgs_pkg and the emergency_priority_green_selector rtl
module emergency_priority_green_selector_tb;
  import epgs_pkg::*;

  localparam int ROADS = NUM_ROADS_DEF;
  localparam int HALF_PERIOD = 4;
  localparam logic [CFG_W-1:0] CFG_TOP = '1;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int DIR_ROWS = 25;
  localparam int SPLIT_ROW = 15;
  localparam int FILL_TICKS = 8;

  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [ROAD_W-1:0]  green_road;
    logic               green_valid;
    logic               is_emergency;
    logic [DUR_W-1:0]   duration;
    logic [COUNT_W-1:0] road_count;
    logic [TOTAL_W-1:0] total;
  } junction_view_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ROAD_W-1:0] rd;
    logic              amb;
    bit                typed;
    junction_view_t    want;
  } stim_row_t;

  localparam junction_view_t UNTYPED = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      operation = '0;
  logic [ROAD_W-1:0]    road = '0;
  logic                 is_ambulance = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROAD_W-1:0]    green_road;
  logic                 green_valid;
  logic                 is_emergency;
  logic [DUR_W-1:0]     green_duration;
  logic [COUNT_W-1:0]   road_count;
  logic [TOTAL_W-1:0]   total_vehicles;

  emergency_priority_green_selector dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // predicted junction state
  logic [COUNT_W-1:0] veh_cnt [ROADS] = '{default: '0};
  logic [WAIT_W-1:0]  wait_acc [ROADS] = '{default: '0};
  logic               emerg_flag [ROADS] = '{default: 1'b0};
  logic [ROAD_W-1:0]  grn_road = '0;
  logic               grn_valid = 1'b0;
  logic               emerg_pick = 1'b0;
  logic [DUR_W-1:0]   grant_len = '0;
  logic [CFG_W-1:0]   cfg_min_green = MIN_GREEN_RST;
  logic [CFG_W-1:0]   cfg_max_green = MAX_GREEN_RST;

  junction_view_t pending_views [$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  send_gap_max = 5;
  int  recv_gap_max = 5;
  bit  hold_off_req = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_SPARE_LO,  2'd3, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd0, 12'd0}},
    '{OP_REMOVE,    2'd2, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd0, 12'd0}},
    '{OP_TICK,      2'd1, 1'b1, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd0, 12'd0}},
    '{OP_ADD,       2'd3, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd1, 12'd1}},
    '{OP_ADD,       2'd3, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd2, 12'd2}},
    '{OP_ADD,       2'd1, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd1, 12'd3}},
    '{OP_TICK,      2'd3, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 10'd0,  10'd2, 12'd3}},
    '{OP_DECIDE,    2'd0, 1'b1, 1'b1, '{2'd3, 1'b1, 1'b0, 10'd12, 10'd0, 12'd3}},
    '{OP_TICK,      2'd3, 1'b0, 1'b1, '{2'd3, 1'b1, 1'b0, 10'd12, 10'd1, 12'd2}},
    '{OP_REMOVE,    2'd1, 1'b0, 1'b1, '{2'd3, 1'b1, 1'b0, 10'd12, 10'd0, 12'd1}},
    '{OP_SPARE_HI,  2'd3, 1'b1, 1'b1, '{2'd3, 1'b1, 1'b0, 10'd12, 10'd1, 12'd1}},
    '{OP_SPARE_MID, 2'd0, 1'b0, 1'b0, UNTYPED},
    '{OP_TICK,      2'd3, 1'b0, 1'b1, '{2'd3, 1'b1, 1'b0, 10'd12, 10'd0, 12'd0}},
    '{OP_TICK,      2'd3, 1'b0, 1'b0, UNTYPED},
    '{OP_DECIDE,    2'd2, 1'b0, 1'b1, '{2'd1, 1'b1, 1'b0, 10'd10, 10'd0, 12'd0}},
    '{OP_EMERG,     2'd2, 1'b1, 1'b0, UNTYPED},
    '{OP_ADD,       2'd1, 1'b1, 1'b0, UNTYPED},
    '{OP_ADD,       2'd1, 1'b0, 1'b0, UNTYPED},
    '{OP_DECIDE,    2'd1, 1'b0, 1'b0, UNTYPED},
    '{OP_TICK,      2'd1, 1'b0, 1'b0, UNTYPED},
    '{OP_EMERG,     2'd0, 1'b0, 1'b0, UNTYPED},
    '{OP_DECIDE,    2'd3, 1'b1, 1'b0, UNTYPED},
    '{OP_REMOVE,    2'd0, 1'b1, 1'b0, UNTYPED},
    '{OP_TICK,      2'd2, 1'b1, 1'b0, UNTYPED},
    '{OP_SPARE_LO,  2'd1, 1'b0, 1'b0, UNTYPED}
  };

  function automatic junction_view_t advance_junction(logic [OP_W-1:0] op,
                                                      logic [ROAD_W-1:0] rd, logic amb);
    junction_view_t v;
    int unsigned score;
    int unsigned best_score;
    int unsigned len;
    int unsigned sum;
    int best;
    int hit;
    case (op)
      OP_ADD: begin
        if (veh_cnt[rd] != COUNT_MAX) veh_cnt[rd] = veh_cnt[rd] + 1'b1;
        if (amb) emerg_flag[rd] = 1'b1;
      end
      OP_REMOVE: begin
        if (veh_cnt[rd] != '0) veh_cnt[rd] = veh_cnt[rd] - 1'b1;
      end
      OP_EMERG: emerg_flag[rd] = 1'b1;
      OP_DECIDE: begin
        hit = -1;
        for (int i = ROADS - 1; i >= 0; i--) if (emerg_flag[i]) hit = i;
        if (hit >= 0) begin
          grn_road = hit[ROAD_W-1:0];
          emerg_pick = 1'b1;
          grant_len = cfg_max_green;
        end else begin
          best = 0;
          best_score = veh_cnt[0] + wait_acc[0];
          for (int i = 1; i < ROADS; i++) begin
            score = veh_cnt[i] + wait_acc[i];
            if (score > best_score) begin
              best_score = score;
              best = i;
            end
          end
          len = cfg_min_green + veh_cnt[best];
          grn_road = best[ROAD_W-1:0];
          emerg_pick = 1'b0;
          grant_len = (len > cfg_max_green) ? cfg_max_green : len[DUR_W-1:0];
        end
        grn_valid = 1'b1;
      end
      OP_TICK: begin
        for (int i = 0; i < ROADS; i++) begin
          if (grn_valid && i == grn_road) begin
            if (veh_cnt[i] != '0) begin
              veh_cnt[i] = veh_cnt[i] - 1'b1;
              if (wait_acc[i] >= WAIT_STEP) wait_acc[i] = wait_acc[i] - WAIT_STEP;
            end
          end else if (veh_cnt[i] != '0) begin
            wait_acc[i] = (wait_acc[i] > WAIT_MAX - WAIT_STEP) ? WAIT_MAX
                                                                : wait_acc[i] + WAIT_STEP;
          end
        end
      end
      default: ;
    endcase
    sum = 0;
    for (int i = 0; i < ROADS; i++) sum += veh_cnt[i];
    if (sum > TOTAL_MAX) sum = TOTAL_MAX;
    v.green_road = grn_valid ? grn_road : '0;
    v.green_valid = grn_valid;
    v.is_emergency = emerg_pick;
    v.duration = grant_len;
    v.road_count = veh_cnt[rd];
    v.total = sum[TOTAL_W-1:0];
    return v;
  endfunction

  task automatic offer_word(logic [OP_W-1:0] op, logic [ROAD_W-1:0] rd, logic amb,
                            bit typed, junction_view_t typed_view);
    int gap;
    junction_view_t view;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    road <= rd;
    is_ambulance <= amb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    view = advance_junction(op, rd, amb);
    if (typed) view = typed_view;
    pending_views.insert(pending_views.size(), view);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_GREEN) cfg_min_green = val;
    else cfg_max_green = val;
    @(negedge clk);
  endtask

  task automatic play_rows(int lo, int hi);
    for (int r = lo; r < hi; r++)
      offer_word(dir_rows[r].op, dir_rows[r].rd, dir_rows[r].amb, dir_rows[r].typed,
                 dir_rows[r].want);
  endtask

  task automatic random_words(int n, bit with_emergency);
    int pick;
    logic [OP_W-1:0] op;
    logic amb;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        send_gap_max = $urandom_range(0, 1) ? 5 : 0;
        recv_gap_max = $urandom_range(0, 1) ? 5 : 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_ADD;
      else if (pick < 45) op = OP_REMOVE;
      else if (pick < 60) op = OP_DECIDE;
      else if (pick < 85) op = OP_TICK;
      else if (pick < 95) op = with_emergency ? OP_EMERG : OP_ADD;
      else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      amb = 1'($urandom_range(0, 1));
      if (op == OP_ADD) amb = with_emergency && ($urandom_range(0, 9) == 0);
      offer_word(op, ROAD_W'($urandom_range(0, ROADS - 1)), amb, 1'b0, UNTYPED);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    junction_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: word out with nothing expected", $time);
        fail_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("green_road", want.green_road, green_road);
        check_field("green_valid", want.green_valid, green_valid);
        check_field("is_emergency", want.is_emergency, is_emergency);
        check_field("green_duration", want.duration, green_duration);
        check_field("road_count", want.road_count, road_count);
        check_field("total_vehicles", want.total, total_vehicles);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_drain
    int hold;
    @(negedge clk);
    forever begin
      hold = $urandom_range(0, recv_gap_max);
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [ROAD_W-1:0] sat_road;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    play_rows(0, SPLIT_ROW);

    write_reg(REG_MIN_GREEN, '0);
    write_reg(REG_MAX_GREEN, CFG_TOP);
    random_words(40, 1'b0);
    write_reg(REG_MIN_GREEN, CFG_TOP);
    write_reg(REG_MAX_GREEN, '0);
    random_words(40, 1'b0);
    write_reg(REG_MIN_GREEN, 10'd7);
    write_reg(REG_MAX_GREEN, 10'd25);
    hold_off_req = 1'b1;
    random_words(80, 1'b0);
    write_reg(REG_MIN_GREEN, CFG_W'($urandom_range(0, CFG_TOP)));
    write_reg(REG_MAX_GREEN, CFG_W'($urandom_range(0, CFG_TOP)));
    random_words(40, 1'b0);

    // fill a red road to the count limit, then let it wait a few ticks
    write_reg(REG_MIN_GREEN, CFG_TOP);
    write_reg(REG_MAX_GREEN, CFG_TOP);
    sat_road = grn_road + 1'b1;
    repeat (COUNT_MAX + 6) offer_word(OP_ADD, sat_road, 1'b0, 1'b0, UNTYPED);
    repeat (FILL_TICKS) offer_word(OP_TICK, sat_road, 1'b0, 1'b0, UNTYPED);
    offer_word(OP_DECIDE, sat_road, 1'b0, 1'b0, UNTYPED);

    write_reg(REG_MIN_GREEN, MIN_GREEN_RST);
    write_reg(REG_MAX_GREEN, MAX_GREEN_RST);
    play_rows(SPLIT_ROW, DIR_ROWS);
    for (int c = 0; c < 4; c++) begin
      write_reg(REG_MIN_GREEN, CFG_W'($urandom_range(0, CFG_TOP)));
      write_reg(REG_MAX_GREEN, (c == 0) ? '0 : CFG_W'($urandom_range(0, CFG_TOP)));
      random_words(25, 1'b1);
    end

    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== emergency_priority_green_selector.f =====
+incdir+src
src/epgs_pkg.sv
src/epgs_ram.sv
src/emergency_priority_green_selector.sv
sim/emergency_priority_green_selector_tb.sv
